// ===== src/assert_macros.svh =====
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== src/tbrl_pkg.sv =====
package tbrl_pkg;

   // q16.16 token values and register width
   localparam int unsigned TOKEN_W = 32;

   // register reset values
   localparam logic [TOKEN_W-1:0] CAPACITY_RESET = 32'd6553600;
   localparam logic [TOKEN_W-1:0] RATE_RESET     = 32'd65536;

   // register indexes
   localparam logic REG_CAPACITY = 1'b0;
   localparam logic REG_RATE     = 1'b1;

   // one classified request as it sits in the queue
   typedef struct packed {
      logic               nonzero;
      logic               refill_ovf;
      logic [TOKEN_W-1:0] refill_add;
      logic [TOKEN_W-1:0] amount;
   } tbrl_entry_type;

   // a word moving between two parts
   typedef struct packed {
      logic           valid;
      tbrl_entry_type entry;
   } tbrl_xfer_type;

endpackage

// ===== src/token_bucket_rate_limiter.sv =====
// token bucket rate limiter, q16.16 tokens
//
// request channel (req_valid / req_stall): req_now_ms is a free-running
// millisecond stamp, req_request_amount the tokens asked for. a zero amount
// is denied and leaves the bucket and the time stamp alone.
// result channel (rsp_valid / rsp_stall): one word per request, in order,
// giving rsp_allowed and the bucket level after the request.
// apb port: register 0 at byte 0 is the capacity (a write also fills the
// bucket), register 1 at byte 4 the refill per millisecond.
//
// one word per cycle sustained while the receiver does not stall; a request
// passes the front stage register, the small queue between front and back
// and the output register the back owns before its result shows. the front
// measures elapsed time and runs the refill multiply, the back keeps the level
// and does the add, compare and subtract combinationally. when the receiver
// stalls, the result holds, the queue fills and req_stall rises once the queue
// has no room for words still in flight. reset loads the capacity and rate
// reset values, fills the bucket and clears the last time stamp.
module token_bucket_rate_limiter
   import tbrl_pkg::*;
#(
   parameter int unsigned TIME_WIDTH  = 32,
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [TOKEN_W-1:0]   req_now_ms,
   input  logic [TOKEN_W-1:0]   req_request_amount,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_allowed,
   output logic [TOKEN_W-1:0]   rsp_tokens_left,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [2:0]           paddr,
   input  logic [TOKEN_W-1:0]   pwdata,
   output logic [TOKEN_W-1:0]   prdata,
   output logic                 pready
);

   localparam int unsigned CW = $clog2(QUEUE_DEPTH+1);

   logic                 csr_write;
   logic                 reg_index;
   logic                 capacity_write;
   logic [TOKEN_W-1:0]   capacity_ff, capacity_in;
   logic [TOKEN_W-1:0]   rate_ff, rate_in;
   tbrl_xfer_type        push;
   tbrl_xfer_type        pop;
   logic                 pop_ready;
   logic [CW-1:0]        queue_count;

   // register port
   assign pready         = 1'b1;
   assign reg_index      = paddr[2];
   assign csr_write      = psel && penable && pwrite && pready;
   assign capacity_write = csr_write && (reg_index == REG_CAPACITY);

   always_comb begin
      capacity_in = capacity_ff;
      rate_in     = rate_ff;
      if (csr_write) begin
         case (reg_index)
            REG_CAPACITY: capacity_in = pwdata;
            REG_RATE:     rate_in     = pwdata;
            default:      ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
         rate_ff     <= RATE_RESET;
      end else begin
         capacity_ff <= capacity_in;
         rate_ff     <= rate_in;
      end
   end

   // register read back
   always_comb begin
      case (reg_index)
         REG_CAPACITY: prdata = capacity_ff;
         REG_RATE:     prdata = rate_ff;
         default:      prdata = '0;
      endcase
   end

   // front: accept, classify, refill multiply
   tbrl_front #(
      .TIME_WIDTH  (TIME_WIDTH),
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_now_ms         (req_now_ms),
      .req_request_amount (req_request_amount),
      .refill_rate        (rate_ff),
      .queue_count        (queue_count),
      .push               (push)
   );

   // decoupling queue
   tbrl_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop_ready (pop_ready),
      .pop       (pop),
      .count     (queue_count)
   );

   // back: bucket level and verdict
   tbrl_back u_back (
      .clock           (clock),
      .reset           (reset),
      .pop             (pop),
      .pop_ready       (pop_ready),
      .capacity        (capacity_ff),
      .capacity_write  (capacity_write),
      .capacity_data   (pwdata),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_allowed     (rsp_allowed),
      .rsp_tokens_left (rsp_tokens_left)
   );

endmodule

// ===== src/tbrl_queue.sv =====
module tbrl_queue
   import tbrl_pkg::*;
#(
   parameter int unsigned DEPTH = 4
) (
   input  logic                             clock,
   input  logic                             reset,
   input  tbrl_xfer_type                    push,
   input  logic                             pop_ready,
   output tbrl_xfer_type                    pop,
   output logic [$clog2(DEPTH+1)-1:0]       count
);

   localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH+1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

   tbrl_entry_type entries_ff [DEPTH];
   logic [PW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]  count_ff, count_in;
   logic           do_pop;

   // head word is shown whenever the queue holds something
   assign pop.valid = (count_ff != '0);
   assign pop.entry = entries_ff[rd_ptr_ff];
   assign do_pop    = pop.valid && pop_ready;
   assign count     = count_ff;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push.valid && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push.valid && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage write
   always_ff @(posedge clock) begin
      if (push.valid) begin
         entries_ff[wr_ptr_ff] <= push.entry;
      end
   end

endmodule

// ===== src/tbrl_front.sv =====
module tbrl_front
   import tbrl_pkg::*;
#(
   parameter int unsigned TIME_WIDTH  = 32,
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [TOKEN_W-1:0]                 req_now_ms,
   input  logic [TOKEN_W-1:0]                 req_request_amount,
   input  logic [TOKEN_W-1:0]                 refill_rate,
   input  logic [$clog2(QUEUE_DEPTH+1)-1:0]   queue_count,
   output tbrl_xfer_type                      push
);

   localparam int unsigned CW = $clog2(QUEUE_DEPTH+1);

   logic                    accept;
   logic                    nonzero;
   logic [TIME_WIDTH-1:0]   now_t;
   logic [TIME_WIDTH-1:0]   elapsed;
   logic [63:0]             elapsed_wide;
   logic [CW:0]             in_flight;
   logic [2*TOKEN_W-1:0]    product;

   logic [TIME_WIDTH-1:0]   last_ff, last_in;
   logic                    s1_valid_ff;
   logic                    s1_nonzero_ff;
   logic                    s1_long_ff;
   logic [TOKEN_W-1:0]      s1_elapsed_ff;
   logic [TOKEN_W-1:0]      s1_amount_ff;

   // stall once the queue could not take everything already in flight
   assign in_flight = {1'b0, queue_count} + (CW+1)'(s1_valid_ff);
   assign req_stall = (in_flight >= (CW+1)'(QUEUE_DEPTH));
   assign accept    = req_valid && !req_stall;

   // classify and measure elapsed time against the last refill stamp
   assign nonzero      = (req_request_amount != '0);
   assign now_t        = TIME_WIDTH'(req_now_ms);
   assign elapsed      = now_t - last_ff;
   assign elapsed_wide = 64'(elapsed);

   always_comb begin
      last_in = last_ff;
      if (accept && nonzero) begin
         last_in = now_t;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff     <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         last_ff     <= last_in;
         s1_valid_ff <= accept;
      end
   end

   // first stage payload
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_nonzero_ff <= nonzero;
         s1_long_ff    <= (elapsed_wide[63:32] != '0);
         s1_elapsed_ff <= elapsed_wide[31:0];
         s1_amount_ff  <= req_request_amount;
      end
   end

   // refill amount, written straight into the queue
   assign product = {{TOKEN_W{1'b0}}, s1_elapsed_ff} * {{TOKEN_W{1'b0}}, refill_rate};

   always_comb begin
      push.valid            = s1_valid_ff;
      push.entry.nonzero    = s1_nonzero_ff;
      push.entry.refill_ovf = (product[2*TOKEN_W-1:TOKEN_W] != '0)
                              || (s1_long_ff && (refill_rate != '0));
      push.entry.refill_add = product[TOKEN_W-1:0];
      push.entry.amount     = s1_amount_ff;
   end

endmodule

// ===== src/tbrl_back.sv =====
module tbrl_back
   import tbrl_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  tbrl_xfer_type        pop,
   output logic                 pop_ready,
   input  logic [TOKEN_W-1:0]   capacity,
   input  logic                 capacity_write,
   input  logic [TOKEN_W-1:0]   capacity_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_allowed,
   output logic [TOKEN_W-1:0]   rsp_tokens_left
);

   logic                 take;
   logic [TOKEN_W-1:0]   headroom;
   logic                 fills;
   logic [TOKEN_W-1:0]   refilled;
   logic                 grant;
   logic [TOKEN_W-1:0]   level_next;

   logic [TOKEN_W-1:0]   level_ff, level_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_allowed_ff;
   logic [TOKEN_W-1:0]   rsp_left_ff;

   // output register frees up when empty or being taken
   assign pop_ready = !rsp_valid_ff || !rsp_stall;
   assign take      = pop.valid && pop_ready;

   // saturating refill, then the grant decision
   assign headroom = (level_ff < capacity) ? capacity - level_ff : '0;
   assign fills    = pop.entry.refill_ovf || (pop.entry.refill_add >= headroom);
   assign refilled = fills ? capacity : level_ff + pop.entry.refill_add;
   assign grant    = pop.entry.nonzero && (refilled >= pop.entry.amount);

   always_comb begin
      if (!pop.entry.nonzero) begin
         level_next = level_ff;
      end else if (grant) begin
         level_next = refilled - pop.entry.amount;
      end else begin
         level_next = refilled;
      end
   end

   // level update; a capacity write refills the bucket
   always_comb begin
      level_in     = level_ff;
      rsp_valid_in = rsp_valid_ff;
      if (capacity_write) begin
         level_in = capacity_data;
      end else if (take) begin
         level_in = level_next;
      end
      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff     <= CAPACITY_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         level_ff     <= level_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result word
   always_ff @(posedge clock) begin
      if (take) begin
         rsp_allowed_ff <= grant;
         rsp_left_ff    <= level_next;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_allowed     = rsp_allowed_ff;
   assign rsp_tokens_left = rsp_left_ff;

endmodule

// ===== src/tbrl_checker.sv =====
`include "assert_macros.svh"

module tbrl_checker
   import tbrl_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic                 rsp_allowed,
   input logic [TOKEN_W-1:0]   rsp_tokens_left
);

   localparam int unsigned OW = $clog2(QUEUE_DEPTH+2) + 1;
   localparam logic [OW-1:0] OUT_MAX = OW'(QUEUE_DEPTH + 1);

   logic            in_take;
   logic            out_take;
   logic [OW-1:0]   pending_ff, pending_in;

   assign in_take  = req_valid && !req_stall;
   assign out_take = rsp_valid && !rsp_stall;

   // words taken but not yet delivered
   always_comb begin
      pending_in = pending_ff;
      if (in_take && !out_take) begin
         pending_in = pending_ff + 1'b1;
      end else if (!in_take && out_take) begin
         pending_in = pending_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // a stalled result holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_allowed) && $stable(rsp_tokens_left))

   // no result without a request behind it
   `ASSERT_IMPLY(a_rsp_has_req, clock, reset, rsp_valid, pending_ff != '0)

   // front stalls before more than the queue depth plus one words are in flight
   `ASSERT_IMPLY(a_pending_bound, clock, reset, 1'b1, pending_ff <= OUT_MAX)

   // reset empties the result register
   `ASSERT_NEXT(a_reset_clear, clock, 1'b0, reset, !rsp_valid)

endmodule

bind token_bucket_rate_limiter tbrl_checker #(
   .QUEUE_DEPTH (QUEUE_DEPTH)
) u_tbrl_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_allowed     (rsp_allowed),
   .rsp_tokens_left (rsp_tokens_left)
);

// ===== tb/tb.sv =====
module tb
   import tbrl_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DRAIN_CYCLES = 8;
   localparam int RANDOM_ITEMS = 500;

   // directed table row kinds
   typedef enum logic [1:0] {
      ROW_REQUEST,
      ROW_CAPACITY,
      ROW_RATE
   } row_kind_type;

   typedef struct packed {
      row_kind_type       kind;
      logic [TOKEN_W-1:0] stamp;
      logic [TOKEN_W-1:0] value;
      logic               typed;
      logic               allowed;
      logic [TOKEN_W-1:0] left;
   } row_type;

   typedef struct packed {
      logic               allowed;
      logic [TOKEN_W-1:0] left;
   } grant_type;

   localparam int N_ROWS = 30;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [TOKEN_W-1:0] req_now_ms = '0;
   logic [TOKEN_W-1:0] req_request_amount = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic               rsp_allowed;
   logic [TOKEN_W-1:0] rsp_tokens_left;
   logic               psel = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite = 1'b0;
   logic [2:0]         paddr = '0;
   logic [TOKEN_W-1:0] pwdata = '0;
   logic [TOKEN_W-1:0] prdata;
   logic               pready;

   // bucket predictor state
   logic [TOKEN_W-1:0] cap_q   = CAPACITY_RESET;
   logic [TOKEN_W-1:0] rate_q  = RATE_RESET;
   logic [TOKEN_W-1:0] level_q = CAPACITY_RESET;
   logic [TOKEN_W-1:0] stamp_q = '0;
   grant_type          grant_queue [$];

   // hand-typed expectation riding along with the current word
   logic               hand_typed = 1'b0;
   grant_type          hand_grant = '0;

   // idling controls
   bit                 send_steady = 1'b0;
   bit                 sink_steady = 1'b0;
   int                 sink_hold = 0;

   int                 errors = 0;
   int                 words_sent = 0;
   int                 results_seen = 0;
   int                 granted_seen = 0;
   int                 csr_writes = 0;

   row_type            directed_rows [N_ROWS];

   token_bucket_rate_limiter u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_now_ms         (req_now_ms),
      .req_request_amount (req_request_amount),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_allowed        (rsp_allowed),
      .rsp_tokens_left    (rsp_tokens_left),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   // clock, 8 ns period
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   task automatic report_mismatch(input string what, input logic [TOKEN_W-1:0] want,
                                  input logic [TOKEN_W-1:0] got);
      $display("%0t ns: %s differs, expected %h got %h", $time, what, want, got);
      errors++;
   endtask

   // refill by elapsed time, then take the amount if the bucket holds it
   function automatic grant_type refill_and_take(input logic [TOKEN_W-1:0] stamp,
                                                 input logic [TOKEN_W-1:0] amount);
      grant_type          g;
      logic [TOKEN_W-1:0] elapsed;
      logic [TOKEN_W-1:0] headroom;
      g.allowed = 1'b0;
      if (amount != '0) begin
         elapsed  = stamp - stamp_q;
         headroom = (level_q < cap_q) ? cap_q - level_q : '0;
         if (level_q > cap_q) level_q = cap_q;
         if (rate_q != '0 && elapsed != '0) begin
            // product fits in 32 bits whenever it does not saturate
            if (elapsed > headroom / rate_q) level_q = cap_q;
            else level_q = level_q + elapsed * rate_q;
         end
         stamp_q = stamp;
         if (level_q >= amount) begin
            level_q   = level_q - amount;
            g.allowed = 1'b1;
         end
      end
      g.left = level_q;
      return g;
   endfunction

   // sample register writes, accepted words and results
   always @(posedge clock) begin : monitor
      grant_type g;
      if (!reset) begin
         if (psel && penable && pwrite && pready) begin
            if (paddr == {REG_CAPACITY, 2'b00}) begin
               cap_q   = pwdata;
               level_q = pwdata;
            end else if (paddr == {REG_RATE, 2'b00}) begin
               rate_q = pwdata;
            end
         end
         if (req_valid && !req_stall) begin
            g = refill_and_take(req_now_ms, req_request_amount);
            if (hand_typed) g = hand_grant;
            grant_queue.push_back(g);
         end
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (rsp_allowed) granted_seen++;
            if (grant_queue.size() == 0) begin
               report_mismatch("unexpected result word", '0, rsp_tokens_left);
            end else begin
               g = grant_queue.pop_front();
               if (rsp_allowed !== g.allowed)
                  report_mismatch("allowed", 32'(g.allowed), 32'(rsp_allowed));
               if (rsp_tokens_left !== g.left)
                  report_mismatch("tokens_left", g.left, rsp_tokens_left);
            end
         end
      end
   end

   // receiver stalls: mostly short, a few long, none in steady phases
   always @(negedge clock) begin : sink
      int r;
      if (sink_hold > 0) begin
         sink_hold--;
      end else if (sink_steady) begin
         rsp_stall = 1'b0;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 60) begin
            rsp_stall = 1'b0;
            sink_hold = $urandom_range(0, 3);
         end else if (r < 93) begin
            rsp_stall = 1'b1;
            sink_hold = $urandom_range(0, 2);
         end else begin
            rsp_stall = 1'b1;
            sink_hold = $urandom_range(10, 40);
         end
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (send_steady || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // one request word, called at a falling edge
   task automatic send_request(input logic [TOKEN_W-1:0] stamp,
                               input logic [TOKEN_W-1:0] amount,
                               input logic typed, input grant_type want);
      req_now_ms         = stamp;
      req_request_amount = amount;
      hand_typed         = typed;
      hand_grant         = want;
      req_valid          = 1'b1;
      do @(posedge clock); while (req_stall);
      words_sent++;
      @(negedge clock);
      req_valid  = 1'b0;
      hand_typed = 1'b0;
      repeat (pick_gap()) @(negedge clock);
   endtask

   task automatic wait_drained();
      while (grant_queue.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // apb setup and access cycles; a read is checked against the register copy
   task automatic csr_access(input logic wr, input logic idx, input logic [TOKEN_W-1:0] data);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = wr;
      paddr   = {idx, 2'b00};
      pwdata  = data;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      if (!wr && prdata !== ((idx == REG_CAPACITY) ? cap_q : rate_q))
         report_mismatch("register readback", (idx == REG_CAPACITY) ? cap_q : rate_q, prdata);
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
   endtask

   task automatic set_register(input logic idx, input logic [TOKEN_W-1:0] data);
      wait_drained();
      csr_access(1'b1, idx, data);
      csr_access(1'b0, idx, data);
      csr_writes++;
   endtask

   initial begin : stimulus
      row_type            row;
      logic [TOKEN_W-1:0] clk_ms;
      logic [TOKEN_W-1:0] amount;
      logic [TOKEN_W-1:0] cap_set;
      logic [TOKEN_W-1:0] rate_set;
      logic [TOKEN_W-1:0] scale;
      int                 n;
      int                 r;
      int                 target;

      // directed rows: reset state, extremes, wrap, zero rate and capacity
      directed_rows = '{
         '{ROW_REQUEST,  32'd0,        32'd0,        1'b1, 1'b0, 32'd6553600},
         '{ROW_REQUEST,  32'd0,        32'hFFFFFFFF, 1'b1, 1'b0, 32'd6553600},
         '{ROW_REQUEST,  32'd0,        32'd1,        1'b1, 1'b1, 32'd6553599},
         '{ROW_REQUEST,  32'd0,        32'd6553599,  1'b1, 1'b1, 32'd0},
         '{ROW_REQUEST,  32'd0,        32'd1,        1'b1, 1'b0, 32'd0},
         '{ROW_REQUEST,  32'd5,        32'd327680,   1'b1, 1'b1, 32'd0},
         '{ROW_REQUEST,  32'd3,        32'd1,        1'b1, 1'b1, 32'd6553599},
         '{ROW_REQUEST,  32'hFFFFFFFF, 32'd0,        1'b1, 1'b0, 32'd6553599},
         '{ROW_REQUEST,  32'd4,        32'd65536,    1'b0, 1'b0, 32'd0},
         '{ROW_RATE,     32'd0,        32'd0,        1'b0, 1'b0, 32'd0},
         '{ROW_REQUEST,  32'd1000,     32'd65536,    1'b0, 1'b0, 32'd0},
         '{ROW_CAPACITY, 32'd0,        32'd0,        1'b0, 1'b0, 32'd0},
         '{ROW_REQUEST,  32'd2000,     32'd1,        1'b1, 1'b0, 32'd0},
         '{ROW_RATE,     32'd0,        32'hFFFFFFFF, 1'b0, 1'b0, 32'd0},
         '{ROW_REQUEST,  32'd2001,     32'd1,        1'b1, 1'b0, 32'd0},
         '{ROW_REQUEST,  32'd2001,     32'd0,        1'b1, 1'b0, 32'd0},
         '{ROW_CAPACITY, 32'd0,        32'hFFFFFFFF, 1'b0, 1'b0, 32'd0},
         '{ROW_REQUEST,  32'd2001,     32'hFFFFFFFF, 1'b1, 1'b1, 32'd0},
         '{ROW_REQUEST,  32'd2002,     32'hFFFFFFFF, 1'b0, 1'b0, 32'd0},
         '{ROW_REQUEST,  32'd2002,     32'd1,        1'b1, 1'b0, 32'd0},
         '{ROW_RATE,     32'd0,        32'd1,        1'b0, 1'b0, 32'd0},
         '{ROW_REQUEST,  32'd2012,     32'd10,       1'b1, 1'b1, 32'd0},
         '{ROW_REQUEST,  32'd2013,     32'd2,        1'b1, 1'b0, 32'd1},
         '{ROW_CAPACITY, 32'd0,        CAPACITY_RESET, 1'b0, 1'b0, 32'd0},
         '{ROW_RATE,     32'd0,        RATE_RESET,   1'b0, 1'b0, 32'd0},
         '{ROW_REQUEST,  32'h80000000, 32'h12345678, 1'b1, 1'b0, 32'd6553600},
         '{ROW_REQUEST,  32'h80000000, 32'h00010000, 1'b1, 1'b1, 32'd6488064},
         '{ROW_REQUEST,  32'h80000000, 32'hAAAA5555, 1'b0, 1'b0, 32'd0},
         '{ROW_REQUEST,  32'h7FFFFFFF, 32'h55550000, 1'b0, 1'b0, 32'd0},
         '{ROW_REQUEST,  32'h7FFFFFFF, 32'h00008000, 1'b0, 1'b0, 32'd0}
      };

      // synchronous reset, released at a falling edge
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed part
      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         case (row.kind)
            ROW_REQUEST: begin
               send_request(row.stamp, row.value, row.typed, {row.allowed, row.left});
            end
            ROW_CAPACITY: begin
               set_register(REG_CAPACITY, row.value);
            end
            ROW_RATE: begin
               set_register(REG_RATE, row.value);
            end
            default: begin
            end
         endcase
      end

      // random phases, each under its own register setting
      target   = words_sent + RANDOM_ITEMS;
      clk_ms   = $urandom;
      cap_set  = cap_q;
      rate_set = rate_q;
      while (words_sent < target) begin
         r = $urandom_range(0, 99);
         if (r < 5) cap_set = '0;
         else if (r < 15) cap_set = '1;
         else if (r < 30) cap_set = $urandom;
         else if (r < 40) cap_set = CAPACITY_RESET;
         else cap_set = 32'd65536 * $urandom_range(1, 500);
         r = $urandom_range(0, 99);
         if (r < 5) rate_set = '0;
         else if (r < 10) rate_set = '1;
         else if (r < 15) rate_set = 32'd1;
         else if (r < 60) rate_set = (cap_set >> $urandom_range(3, 12)) | 32'd1;
         else if (r < 75) rate_set = $urandom;
         else rate_set = 32'd65536 * $urandom_range(1, 4);

         // write both, or only one of them
         r = $urandom_range(0, 3);
         if (r != 2) set_register(REG_CAPACITY, cap_set);
         if (r != 1) set_register(REG_RATE, rate_set);

         send_steady = ($urandom_range(0, 3) == 0);
         sink_steady = ($urandom_range(0, 3) == 0);
         n = $urandom_range(10, 50);
         repeat (n) begin
            // time mostly creeps forward, sometimes jumps or runs backwards
            r = $urandom_range(0, 99);
            if (r < 60) clk_ms = clk_ms + $urandom_range(0, 8);
            else if (r < 75) clk_ms = clk_ms;
            else if (r < 85) clk_ms = clk_ms + $urandom_range(9, 2000);
            else if (r < 92) clk_ms = clk_ms - $urandom_range(1, 50);
            else clk_ms = $urandom;

            // amounts mostly a fraction of the capacity
            r = $urandom_range(0, 99);
            scale = cap_q >> $urandom_range(0, 6);
            if (scale == '0) scale = 32'd1;
            if (r < 8) amount = '0;
            else if (r < 15) amount = $urandom;
            else if (r < 18) amount = '1;
            else amount = $urandom_range(1, scale);

            send_request(clk_ms, amount, 1'b0, '0);

            // sender holds off until every result is back
            if ($urandom_range(0, 63) == 0) wait_drained();
         end
      end

      wait_drained();
      $display("ran %0d request words through %0d register writes", words_sent, csr_writes);
      $display("checked %0d result words, %0d granted, %0d mismatches",
               results_seen, granted_seen, errors);
      if (errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // hard stop for a hung handshake
   initial begin : watchdog
      #4_000_000;
      $display("timeout with %0d result words outstanding", grant_queue.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+src
src/tbrl_pkg.sv
src/tbrl_queue.sv
src/tbrl_front.sv
src/tbrl_back.sv
src/token_bucket_rate_limiter.sv
src/tbrl_checker.sv
tb/tb.sv
